@@ design/bpc_pkg.sv @@
// Shared constants, field layout and helpers for the bitmask pixel collision block.
// Used by the top level; has no dependencies of its own.
package bpc_pkg;

   // Mask geometry
   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_AW     = $clog2(MAX_HEIGHT);

   // Configuration registers
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 8;
   localparam logic [CSR_W-1:0] CSR_RESET = 8'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_MASK_A_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_A_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_B_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_B_HEIGHT = 2'd3;

   // Request kinds
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COLLIDE = 2'd2;

   // Request layout
   localparam int PIX_W      = 12;
   localparam int POS_W      = 16;
   localparam int POS_EXT_W  = POS_W + 2;
   localparam int REQ_TUSER_W = KIND_W + 1;
   localparam int USER_KIND_LSB = 0;
   localparam int USER_SEL_BIT  = KIND_W;

   localparam int PX_LSB   = 0;
   localparam int PY_LSB   = PX_LSB + PIX_W;
   localparam int VAL_BIT  = PY_LSB + PIX_W;
   localparam int AX_LSB   = VAL_BIT + 1;
   localparam int AY_LSB   = AX_LSB + POS_W;
   localparam int BX_LSB   = AY_LSB + POS_W;
   localparam int BY_LSB   = BX_LSB + POS_W;
   localparam int REQ_USED_W  = BY_LSB + POS_W;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // Response layout
   localparam int RSP_FIELDS    = 3;
   localparam int RSP_TDATA_W   = 8;
   localparam int RSP_READ_BIT  = 0;
   localparam int RSP_OOR       = 1;
   localparam int RSP_COLLIDED  = 2;

   // A size register is clamped to the largest mask the storage holds.
   function automatic logic [CSR_W-1:0] eff_size(input logic [CSR_W-1:0] reg_val,
                                                 input int unsigned limit);
      if (32'(reg_val) > limit) begin
         eff_size = CSR_W'(limit);
      end else begin
         eff_size = reg_val;
      end
   endfunction

endpackage

@@ design/bpc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bitmask_pixel_collision.sv @@
// Top level of the bitmask pixel collision block: two row-organized mask memories,
// a sequencer for pixel and collision transactions, and the output register.
// Depends on bpc_pkg and bpc_ram.
//
//   channel   direction  handshake             payload
//   req       in         req_tvalid/tready     req_tdata, req_tuser
//   rsp       out        rsp_tvalid/tready     rsp_tdata
//   csr       in         csr_wen               csr_index, csr_wdata
//
// A set or read transaction starts in S_PIX; a read loads its response in S_EMIT.
// A collision runs S_BOX, S_PREP, then S_SCAN over up to R rows, R being the number
// of overlapping rows (at most MAX_HEIGHT); each mask memory gives one row per cycle
// to the compare. The scan stops early at the first shared pixel.
// Reset clears a valid flag per row, so no clearing pass is needed; unwritten rows
// read as zero. A stalled response is held while the next transaction is taken.
module bitmask_pixel_collision (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // pixel_x, pixel_y, pixel_value, pos_a_x, pos_a_y, pos_b_x, pos_b_y, zero fill
   input  logic [bpc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // kind, which_mask
   input  logic [bpc_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_bit, out_of_range, collided, zero fill
   output logic [bpc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             csr_wen,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpc_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int W  = bpc_pkg::MAX_WIDTH;
   localparam int H  = bpc_pkg::MAX_HEIGHT;
   localparam int CW = bpc_pkg::COL_W;
   localparam int RW = bpc_pkg::ROW_AW;
   localparam int EW = bpc_pkg::POS_EXT_W;
   localparam int SW = bpc_pkg::CSR_W;
   localparam int PW = bpc_pkg::PIX_W;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_PIX      = 7'b0000010,
      S_PIX_DATA = 7'b0000100,
      S_BOX      = 7'b0001000,
      S_PREP     = 7'b0010000,
      S_SCAN     = 7'b0100000,
      S_EMIT     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [SW-1:0] a_width_ff, a_width_in, a_height_ff, a_height_in;
   logic [SW-1:0] b_width_ff, b_width_in, b_height_ff, b_height_in;

   logic                     is_read_ff, is_read_in;
   logic                     sel_ff, sel_in;
   logic signed [PW-1:0]     px_ff, px_in, py_ff, py_in;
   logic                     val_ff, val_in;
   logic signed [bpc_pkg::POS_W-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;

   logic signed [EW-1:0] xlo_ff, xlo_in, xhi_ff, xhi_in, ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic [CW-1:0]        da_ff, da_in, db_ff, db_in;
   logic [W-1:0]         xmask_ff, xmask_in;
   logic [RW-1:0]        ra_ff, ra_in, rb_ff, rb_in;
   logic [RW:0]          rows_ff, rows_in, iss_ff, iss_in;
   logic                 pend_ff, pend_in, hit_ff, hit_in;

   logic [H-1:0] valid_a_ff, valid_a_in, valid_b_ff, valid_b_in;
   logic         va_ff, va_in, vb_ff, vb_in;

   logic [bpc_pkg::RSP_FIELDS-1:0]  res_ff, res_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bpc_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory ports
   logic          rd_en, wr_en_a, wr_en_b;
   logic [RW-1:0] rd_addr_a, rd_addr_b, wr_addr;
   logic [W-1:0]  wr_row, q_a, q_b;

   // Derived values
   logic [SW-1:0] eff_aw, eff_ah, eff_bw, eff_bh, pix_w, pix_h;
   logic          pix_in_range;
   logic [W-1:0]  row_a_q, row_b_q, pix_row_q;
   logic          row_hit;
   logic signed [EW-1:0] ax_e, ay_e, bx_e, by_e, aw_e, ah_e, bw_e, bh_e;
   logic signed [EW-1:0] ea_x, ea_y, eb_x, eb_y;
   logic signed [EW-1:0] dxa, dxb, dya, dyb, nx, ny;

   assign eff_aw = bpc_pkg::eff_size(a_width_ff, W);
   assign eff_ah = bpc_pkg::eff_size(a_height_ff, H);
   assign eff_bw = bpc_pkg::eff_size(b_width_ff, W);
   assign eff_bh = bpc_pkg::eff_size(b_height_ff, H);
   assign pix_w  = sel_ff ? eff_bw : eff_aw;
   assign pix_h  = sel_ff ? eff_bh : eff_ah;

   // Negative coordinates have the sign bit set; the rest compare as unsigned.
   assign pix_in_range = !px_ff[PW-1] && !py_ff[PW-1]
                         && ({1'b0, px_ff[PW-2:0]} < PW'(pix_w))
                         && ({1'b0, py_ff[PW-2:0]} < PW'(pix_h));

   // Rows never written read as zero.
   assign row_a_q   = q_a & {W{va_ff}};
   assign row_b_q   = q_b & {W{vb_ff}};
   assign pix_row_q = sel_ff ? row_b_q : row_a_q;
   assign row_hit   = |((row_a_q >> da_ff) & (row_b_q >> db_ff) & xmask_ff);

   assign ax_e = EW'(ax_ff);
   assign ay_e = EW'(ay_ff);
   assign bx_e = EW'(bx_ff);
   assign by_e = EW'(by_ff);
   assign aw_e = $signed({{(EW-SW){1'b0}}, eff_aw});
   assign ah_e = $signed({{(EW-SW){1'b0}}, eff_ah});
   assign bw_e = $signed({{(EW-SW){1'b0}}, eff_bw});
   assign bh_e = $signed({{(EW-SW){1'b0}}, eff_bh});
   assign ea_x = ax_e + aw_e;
   assign ea_y = ay_e + ah_e;
   assign eb_x = bx_e + bw_e;
   assign eb_y = by_e + bh_e;
   assign dxa  = xlo_ff - ax_e;
   assign dxb  = xlo_ff - bx_e;
   assign dya  = ylo_ff - ay_e;
   assign dyb  = ylo_ff - by_e;
   assign nx   = xhi_ff - xlo_ff;
   assign ny   = yhi_ff - ylo_ff;

   always_comb begin
      state_in    = state_ff;
      a_width_in  = a_width_ff;
      a_height_in = a_height_ff;
      b_width_in  = b_width_ff;
      b_height_in = b_height_ff;
      is_read_in  = is_read_ff;
      sel_in      = sel_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      val_in      = val_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      bx_in       = bx_ff;
      by_in       = by_ff;
      xlo_in      = xlo_ff;
      xhi_in      = xhi_ff;
      ylo_in      = ylo_ff;
      yhi_in      = yhi_ff;
      da_in       = da_ff;
      db_in       = db_ff;
      xmask_in    = xmask_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      rows_in     = rows_ff;
      iss_in      = iss_ff;
      pend_in     = 1'b0;
      hit_in      = hit_ff;
      valid_a_in  = valid_a_ff;
      valid_b_in  = valid_b_ff;
      res_in      = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      rd_en     = 1'b0;
      rd_addr_a = py_ff[RW-1:0];
      rd_addr_b = py_ff[RW-1:0];
      wr_en_a   = 1'b0;
      wr_en_b   = 1'b0;
      wr_addr   = py_ff[RW-1:0];
      wr_row    = pix_row_q;
      wr_row[px_ff[CW-1:0]] = val_ff;

      if (csr_wen) begin
         case (csr_index)
            bpc_pkg::CSR_MASK_A_WIDTH:  a_width_in  = csr_wdata;
            bpc_pkg::CSR_MASK_A_HEIGHT: a_height_in = csr_wdata;
            bpc_pkg::CSR_MASK_B_WIDTH:  b_width_in  = csr_wdata;
            bpc_pkg::CSR_MASK_B_HEIGHT: b_height_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               is_read_in = (req_tuser[bpc_pkg::USER_KIND_LSB +: bpc_pkg::KIND_W]
                             == bpc_pkg::KIND_READ);
               sel_in = req_tuser[bpc_pkg::USER_SEL_BIT];
               px_in  = req_tdata[bpc_pkg::PX_LSB +: PW];
               py_in  = req_tdata[bpc_pkg::PY_LSB +: PW];
               val_in = req_tdata[bpc_pkg::VAL_BIT];
               ax_in  = req_tdata[bpc_pkg::AX_LSB +: bpc_pkg::POS_W];
               ay_in  = req_tdata[bpc_pkg::AY_LSB +: bpc_pkg::POS_W];
               bx_in  = req_tdata[bpc_pkg::BX_LSB +: bpc_pkg::POS_W];
               by_in  = req_tdata[bpc_pkg::BY_LSB +: bpc_pkg::POS_W];
               case (req_tuser[bpc_pkg::USER_KIND_LSB +: bpc_pkg::KIND_W])
                  bpc_pkg::KIND_SET, bpc_pkg::KIND_READ: state_in = S_PIX;
                  bpc_pkg::KIND_COLLIDE:                 state_in = S_BOX;
                  default:                               state_in = S_IDLE;
               endcase
            end
         end

         S_PIX: begin
            if (pix_in_range) begin
               rd_en    = 1'b1;
               state_in = S_PIX_DATA;
            end else if (is_read_ff) begin
               res_in   = '0;
               res_in[bpc_pkg::RSP_OOR] = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_PIX_DATA: begin
            if (is_read_ff) begin
               res_in   = '0;
               res_in[bpc_pkg::RSP_READ_BIT] = pix_row_q[px_ff[CW-1:0]];
               state_in = S_EMIT;
            end else begin
               // The whole row goes back with only the addressed bit changed.
               wr_en_a  = !sel_ff;
               wr_en_b  = sel_ff;
               if (sel_ff) begin
                  valid_b_in[py_ff[RW-1:0]] = 1'b1;
               end else begin
                  valid_a_in[py_ff[RW-1:0]] = 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         S_BOX: begin
            xlo_in   = (ax_e > bx_e) ? ax_e : bx_e;
            ylo_in   = (ay_e > by_e) ? ay_e : by_e;
            xhi_in   = (ea_x < eb_x) ? ea_x : eb_x;
            yhi_in   = (ea_y < eb_y) ? ea_y : eb_y;
            state_in = S_PREP;
         end

         S_PREP: begin
            if ((xlo_ff < xhi_ff) && (ylo_ff < yhi_ff)) begin
               // Inside the overlap every offset is below the mask size.
               da_in    = dxa[CW-1:0];
               db_in    = dxb[CW-1:0];
               xmask_in = ~({W{1'b1}} << nx[CW:0]);
               ra_in    = dya[RW-1:0];
               rb_in    = dyb[RW-1:0];
               rows_in  = ny[RW:0];
               iss_in   = '0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end else begin
               res_in   = '0;
               state_in = S_EMIT;
            end
         end

         S_SCAN: begin
            if (pend_ff && row_hit) begin
               hit_in = 1'b1;
            end
            rd_addr_a = ra_ff + iss_ff[RW-1:0];
            rd_addr_b = rb_ff + iss_ff[RW-1:0];
            if (hit_ff || ((iss_ff == rows_ff) && !pend_ff)) begin
               res_in   = '0;
               res_in[bpc_pkg::RSP_COLLIDED] = hit_ff;
               state_in = S_EMIT;
            end else if ((iss_ff < rows_ff) && !hit_ff) begin
               rd_en   = 1'b1;
               iss_in  = iss_ff + 1'b1;
               pend_in = 1'b1;
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(bpc_pkg::RSP_TDATA_W - bpc_pkg::RSP_FIELDS){1'b0}}, res_ff};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      va_in = valid_a_ff[rd_addr_a];
      vb_in = valid_b_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_width_ff   <= bpc_pkg::CSR_RESET;
         a_height_ff  <= bpc_pkg::CSR_RESET;
         b_width_ff   <= bpc_pkg::CSR_RESET;
         b_height_ff  <= bpc_pkg::CSR_RESET;
         valid_a_ff   <= '0;
         valid_b_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_width_ff   <= a_width_in;
         a_height_ff  <= a_height_in;
         b_width_ff   <= b_width_in;
         b_height_ff  <= b_height_in;
         valid_a_ff   <= valid_a_in;
         valid_b_ff   <= valid_b_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_read_ff  <= is_read_in;
      sel_ff      <= sel_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      val_ff      <= val_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      xlo_ff      <= xlo_in;
      xhi_ff      <= xhi_in;
      ylo_ff      <= ylo_in;
      yhi_ff      <= yhi_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      xmask_ff    <= xmask_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rows_ff     <= rows_in;
      iss_ff      <= iss_in;
      hit_ff      <= hit_in;
      va_ff       <= va_in;
      vb_ff       <= vb_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   bpc_ram #(.WIDTH(W), .DEPTH(H)) u_mask_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (q_a)
   );

   bpc_ram #(.WIDTH(W), .DEPTH(H)) u_mask_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (q_b)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_collide_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[bpc_pkg::RSP_COLLIDED]
                       && (rsp_tdata[bpc_pkg::RSP_READ_BIT] || rsp_tdata[bpc_pkg::RSP_OOR])))
      else $error("collision response carries pixel read flags");

   a_oor_no_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[bpc_pkg::RSP_READ_BIT] && rsp_tdata[bpc_pkg::RSP_OOR]))
      else $error("out-of-range read returned a set bit");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(wr_en_a && wr_en_b))
      else $error("both mask memories written in one cycle");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (iss_ff <= rows_ff))
      else $error("row scan issued past the overlap");
`endif

endmodule

@@ verif/tb_bitmask_pixel_collision.sv @@
// Self-checking testbench for bitmask_pixel_collision: drives pixel and collision
// transactions over the req stream, checks every rsp transaction against a mask model.
// Depends on bpc_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module tb_bitmask_pixel_collision;
   import bpc_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic MASK_A = 1'b0;
   localparam logic MASK_B = 1'b1;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 135;

   typedef struct {
      logic [KIND_W-1:0]       kind;
      logic                    sel;
      logic signed [PIX_W-1:0] px;
      logic signed [PIX_W-1:0] py;
      logic                    val;
      logic signed [POS_W-1:0] ax;
      logic signed [POS_W-1:0] ay;
      logic signed [POS_W-1:0] bx;
      logic signed [POS_W-1:0] by;
   } pix_req_t;

   typedef struct {
      logic read_bit;
      logic out_of_range;
      logic collided;
   } pix_answer_t;

   // Tracks the contents of both masks and the size registers, and holds the answers
   // the block still owes, oldest first.
   class bitmask_tracker;
      logic [MAX_WIDTH-1:0] rows_a [MAX_HEIGHT];
      logic [MAX_WIDTH-1:0] rows_b [MAX_HEIGHT];
      logic [CSR_W-1:0]     size_reg [4];
      pix_answer_t          owed_answers [$];
      int                   errors;

      function new();
         for (int i = 0; i < MAX_HEIGHT; i++) begin
            rows_a[i] = '0;
            rows_b[i] = '0;
         end
         for (int i = 0; i < 4; i++) size_reg[i] = CSR_RESET;
         errors = 0;
      endfunction

      function void set_size(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] v);
         size_reg[idx] = v;
      endfunction

      // Register value clamped to what the storage holds.
      function int span(logic [CSR_IDX_W-1:0] idx);
         int lim;
         lim = (idx == CSR_MASK_A_WIDTH || idx == CSR_MASK_B_WIDTH) ? MAX_WIDTH : MAX_HEIGHT;
         return (int'(size_reg[idx]) > lim) ? lim : int'(size_reg[idx]);
      endfunction

      function bit covers(logic sel, int x, int y);
         int w, h;
         w = span(sel == MASK_B ? CSR_MASK_B_WIDTH : CSR_MASK_A_WIDTH);
         h = span(sel == MASK_B ? CSR_MASK_B_HEIGHT : CSR_MASK_A_HEIGHT);
         return x >= 0 && y >= 0 && x < w && y < h;
      endfunction

      function logic shared_pixel(int ax, int ay, int bx, int by);
         int wa, ha, wb, hb, xlo, xhi, ylo, yhi;
         logic [MAX_WIDTH-1:0] ra, rb, lenmask, one;
         logic hit;
         wa = span(CSR_MASK_A_WIDTH);
         ha = span(CSR_MASK_A_HEIGHT);
         wb = span(CSR_MASK_B_WIDTH);
         hb = span(CSR_MASK_B_HEIGHT);
         xlo = (ax > bx) ? ax : bx;
         ylo = (ay > by) ? ay : by;
         xhi = (ax + wa < bx + wb) ? ax + wa : bx + wb;
         yhi = (ay + ha < by + hb) ? ay + ha : by + hb;
         hit = 1'b0;
         one = 1;
         if (xhi > xlo) begin
            // A shift by the full row width yields zero, so the mask becomes all ones.
            lenmask = (one << (xhi - xlo)) - one;
            for (int y = ylo; y < yhi && !hit; y++) begin
               ra = rows_a[y - ay] >> (xlo - ax);
               rb = rows_b[y - by] >> (xlo - bx);
               if ((ra & rb & lenmask) != '0) hit = 1'b1;
            end
         end
         return hit;
      endfunction

      function void accept_request(pix_req_t r);
         pix_answer_t a;
         int x, y;
         x = int'(r.px);
         y = int'(r.py);
         a.read_bit = 1'b0;
         a.out_of_range = 1'b0;
         a.collided = 1'b0;
         case (r.kind)
            KIND_SET: begin
               if (covers(r.sel, x, y)) begin
                  if (r.sel == MASK_B) rows_b[y][x] = r.val;
                  else rows_a[y][x] = r.val;
               end
            end
            KIND_READ: begin
               if (covers(r.sel, x, y)) begin
                  a.read_bit = (r.sel == MASK_B) ? rows_b[y][x] : rows_a[y][x];
               end else begin
                  a.out_of_range = 1'b1;
               end
               owed_answers.push_back(a);
            end
            KIND_COLLIDE: begin
               a.collided = shared_pixel(int'(r.ax), int'(r.ay), int'(r.bx), int'(r.by));
               owed_answers.push_back(a);
            end
            default: begin
            end
         endcase
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] d);
         pix_answer_t e;
         if (owed_answers.size() == 0) begin
            errors++;
            if (errors <= 10) $display("mismatch: response %02h arrived with none expected", d);
            return;
         end
         e = owed_answers.pop_front();
         if (d[RSP_READ_BIT] !== e.read_bit || d[RSP_OOR] !== e.out_of_range ||
             d[RSP_COLLIDED] !== e.collided) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch at %0t: expected read_bit=%0d out_of_range=%0d collided=%0d,",
                        $realtime, e.read_bit, e.out_of_range, e.collided,
                        " got read_bit=%0d out_of_range=%0d collided=%0d",
                        d[RSP_READ_BIT], d[RSP_OOR], d[RSP_COLLIDED]);
            end
         end
      endfunction

      function int owed();
         return owed_answers.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]       csr_wdata = '0;

   bitmask_tracker tracker = new();
   bit  req_burst = 1'b0;
   bit  rsp_burst = 1'b0;
   int  rsp_hold;
   int  rsp_wait_left = 0;

   bitmask_pixel_collision uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: after each accepted response it stalls for a random number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait_left <= 0;
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin
            tracker.check_response(rsp_tdata);
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, 15);
            if (rsp_hold != 0) begin
               rsp_tready <= 1'b0;
               rsp_wait_left <= rsp_hold;
            end
         end
      end else begin
         if (rsp_wait_left <= 1) rsp_tready <= 1'b1;
         else rsp_wait_left <= rsp_wait_left - 1;
      end
   end

   function automatic pix_req_t mk(logic [KIND_W-1:0] kind, logic sel, int x, int y,
                                   logic val, int ax, int ay, int bx, int by);
      pix_req_t r;
      r.kind = kind;
      r.sel = sel;
      r.px = PIX_W'(x);
      r.py = PIX_W'(y);
      r.val = val;
      r.ax = POS_W'(ax);
      r.ay = POS_W'(ay);
      r.bx = POS_W'(bx);
      r.by = POS_W'(by);
      return r;
   endfunction

   // Random item shaped by the current sizes: most coordinates land near or inside the
   // masks, and collision positions are mostly close enough for the boxes to overlap.
   function automatic pix_req_t rand_request();
      pix_req_t r;
      int pick, w, h, wa, wb, ha, hb, offx, offy;
      bit hot;
      r.kind = KIND_W'($urandom_range(0, 2));
      r.sel = 1'($urandom());
      r.px = PIX_W'($urandom());
      r.py = PIX_W'($urandom());
      r.val = 1'($urandom());
      r.ax = POS_W'($urandom());
      r.ay = POS_W'($urandom());
      r.bx = POS_W'($urandom());
      r.by = POS_W'($urandom());
      pick = $urandom_range(0, 99);
      hot = 1'($urandom());
      w = tracker.span(r.sel == MASK_B ? CSR_MASK_B_WIDTH : CSR_MASK_A_WIDTH);
      h = tracker.span(r.sel == MASK_B ? CSR_MASK_B_HEIGHT : CSR_MASK_A_HEIGHT);
      if (pick < 70) begin
         r.kind = (pick < 45) ? KIND_SET : KIND_READ;
         r.val = ($urandom_range(0, 99) < 65);
         if (hot) begin
            r.px = PIX_W'(int'($urandom_range(0, (w < 12 ? w : 12) + 1)) - 1);
            r.py = PIX_W'(int'($urandom_range(0, (h < 12 ? h : 12) + 1)) - 1);
         end else begin
            r.px = PIX_W'(int'($urandom_range(0, w + 3)) - 2);
            r.py = PIX_W'(int'($urandom_range(0, h + 3)) - 2);
         end
      end else if (pick < 95) begin
         r.kind = KIND_COLLIDE;
         wa = tracker.span(CSR_MASK_A_WIDTH);
         ha = tracker.span(CSR_MASK_A_HEIGHT);
         wb = tracker.span(CSR_MASK_B_WIDTH);
         hb = tracker.span(CSR_MASK_B_HEIGHT);
         if (hot) begin
            offx = int'($urandom_range(0, 16)) - 8;
            offy = int'($urandom_range(0, 16)) - 8;
         end else begin
            offx = int'($urandom_range(0, wa + wb + 4)) - (wb + 2);
            offy = int'($urandom_range(0, ha + hb + 4)) - (hb + 2);
         end
         r.bx = POS_W'(int'(r.ax) + offx);
         r.by = POS_W'(int'(r.ay) + offy);
      end else if (pick >= 98) begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   // Called at a rising edge; returns at the edge where the transaction is accepted.
   task automatic send(pix_req_t r);
      int gap;
      logic [REQ_TDATA_W-1:0] d;
      if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      d = '0;
      d[PX_LSB +: PIX_W] = r.px;
      d[PY_LSB +: PIX_W] = r.py;
      d[VAL_BIT] = r.val;
      d[AX_LSB +: POS_W] = r.ax;
      d[AY_LSB +: POS_W] = r.ay;
      d[BX_LSB +: POS_W] = r.bx;
      d[BY_LSB +: POS_W] = r.by;
      req_tdata <= d;
      req_tuser <= {r.sel, r.kind};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.accept_request(r);
   endtask

   // Lets the block go idle: all answers in, then room for a trailing set transaction.
   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      while (tracker.owed() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_sizes(logic [CSR_W-1:0] aw, logic [CSR_W-1:0] ah,
                              logic [CSR_W-1:0] bw, logic [CSR_W-1:0] bh);
      logic [CSR_W-1:0] v [4];
      v[CSR_MASK_A_WIDTH] = aw;
      v[CSR_MASK_A_HEIGHT] = ah;
      v[CSR_MASK_B_WIDTH] = bw;
      v[CSR_MASK_B_HEIGHT] = bh;
      for (int i = 0; i < 4; i++) begin
         csr_wen <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= v[i];
         @(posedge clock);
         tracker.set_size(CSR_IDX_W'(i), v[i]);
      end
      csr_wen <= 1'b0;
   endtask

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset sizes.
      send(mk(KIND_READ, MASK_A, 0, 0, 0, 0, 0, 0, 0));
      send(mk(KIND_SET, MASK_A, 0, 0, 1, 0, 0, 0, 0));
      send(mk(KIND_SET, MASK_A, 127, 127, 1, 0, 0, 0, 0));
      send(mk(KIND_SET, MASK_B, 127, 0, 1, 0, 0, 0, 0));
      send(mk(KIND_SET, MASK_B, 0, 127, 1, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_A, 127, 127, 0, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_A, 128, 0, 0, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_A, -1, 0, 0, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_B, 0, -2048, 0, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_B, 2047, 2047, 0, 0, 0, 0, 0));
      // Writes outside the mask must leave it unchanged.
      send(mk(KIND_SET, MASK_A, -1, 5, 1, 0, 0, 0, 0));
      send(mk(KIND_SET, MASK_A, 128, 3, 1, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_A, 127, 5, 0, 0, 0, 0, 0));
      // Clearing one bit must not disturb its neighbor in the same word.
      send(mk(KIND_SET, MASK_A, 1, 0, 1, 0, 0, 0, 0));
      send(mk(KIND_SET, MASK_A, 0, 0, 0, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_A, 1, 0, 0, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_A, 0, 0, 0, 0, 0, 0, 0));
      send(mk(KIND_COLLIDE, MASK_A, 0, 0, 0, 0, 0, 0, 0));
      send(mk(KIND_COLLIDE, MASK_A, 0, 0, 0, 0, 0, -126, 0));
      send(mk(KIND_COLLIDE, MASK_A, 0, 0, 0, 32767, 32767, -32768, -32768));
      send(mk(KIND_COLLIDE, MASK_B, 0, 0, 0, -32768, -32768, -32768, -32768));
      send(mk(KIND_COLLIDE, MASK_B, 0, 0, 0, 32767, 32767, 32640, 32640));
      send(mk(KIND_UNUSED, MASK_A, 3, 3, 1, 0, 0, 0, 0));
      send(mk(KIND_READ, MASK_A, 3, 3, 0, 0, 0, 0, 0));

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            drain(20);
            case (p)
               1: write_sizes(8'd1, 8'd1, 8'd1, 8'd1);
               2: write_sizes(8'd0, 8'd5, 8'd7, 8'd0);
               3: write_sizes(8'd255, 8'd129, 8'd200, 8'd128);
               4: write_sizes(CSR_W'($urandom_range(1, 32)), CSR_W'($urandom_range(1, 32)),
                              CSR_W'($urandom_range(1, 32)), CSR_W'($urandom_range(1, 32)));
               5: write_sizes(CSR_W'($urandom_range(1, 128)), CSR_W'($urandom_range(1, 128)),
                              CSR_W'($urandom_range(1, 128)), CSR_W'($urandom_range(1, 128)));
               6: write_sizes(8'd16, 8'd8, 8'd9, 8'd3);
               default: write_sizes(CSR_W'($urandom()), CSR_W'($urandom()),
                                    CSR_W'($urandom()), CSR_W'($urandom()));
            endcase
         end
         for (int i = 0; i < ITEMS_PER_PHASE; i++) send(rand_request());
      end

      drain(300);
      if (tracker.owed() != 0) begin
         tracker.errors += tracker.owed();
         $display("mismatch: %0d expected responses never arrived", tracker.owed());
      end
      if (tracker.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
